@@ sv/missing_aware_box_mean_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the missing-aware box mean
// Concurrent checks that can be compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef MISSING_AWARE_BOX_MEAN_MACROS_SVH
`define MISSING_AWARE_BOX_MEAN_MACROS_SVH

`ifndef NO_ASSERTIONS
`define MABM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("box mean check failed");
`define MABM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("box mean check failed");
`else
`define MABM_ASSERT_NOW(label, ante, cons)
`define MABM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ sv/mabm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mabm_pkg
// Shared constants, register indexes and flag types of the box mean.
// ----------------------------------------------------------------------------
package mabm_pkg;

  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int DEF_MAX_RADIUS  = 15;
  localparam int DEF_SAMPLE_BITS = 16;
  localparam int QUEUE_DEPTH     = 4;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;
  localparam int WIDTH_BITS     = 11;
  localparam int HEIGHT_BITS    = 16;
  localparam int RADIUS_BITS    = 4;

  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_RADIUS = 2'd2;

  localparam logic [WIDTH_BITS-1:0]  RST_FRAME_WIDTH   = 11'd1024;
  localparam logic [HEIGHT_BITS-1:0] RST_FRAME_HEIGHT  = 16'd1024;
  localparam logic [RADIUS_BITS-1:0] RST_WINDOW_RADIUS = 4'd3;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_PAD   = 1'b1;

  typedef struct packed {
    logic ok;
    logic first_row;
    logic leave_ok;
    logic orow_ok;
    logic row_last;
    logic col_last;
  } job_flags_t;

  typedef struct packed {
    logic run_last;
    logic frame_last;
  } res_flags_t;

endpackage

@@ sv/mabm_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mabm_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mabm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

@@ sv/mabm_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mabm_fifo
// Short register queue between the front end and the back end.
// ----------------------------------------------------------------------------
module mabm_fifo import mabm_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full  = (32'(count) == DEPTH);
  assign empty = (count == '0);
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

@@ sv/mabm_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mabm_front
// Tracks the scan position and classifies each accepted item into a job.
// ----------------------------------------------------------------------------
module mabm_front import mabm_pkg::*; #(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int MAX_RADIUS  = DEF_MAX_RADIUS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     restart,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]           w_eff,
  input  logic [HEIGHT_BITS-1:0]                   h_eff,
  input  logic [$clog2(MAX_RADIUS+1)-1:0]          r_eff,
  input  logic                                     accept,
  input  logic                                     op,
  input  logic signed [SAMPLE_BITS-1:0]            sample,
  input  logic                                     sample_valid,
  output job_flags_t                               job_flags,
  output logic [$clog2(MAX_WIDTH)-1:0]             job_col,
  output logic [$clog2(2*MAX_RADIUS+1)-1:0]        job_wr_slot,
  output logic [$clog2(2*MAX_RADIUS+1)-1:0]        job_leave_slot,
  output logic signed [SAMPLE_BITS-1:0]            job_value
);

  localparam int COLW  = $clog2(MAX_WIDTH);
  localparam int RING  = 2 * MAX_RADIUS + 1;
  localparam int SLOTW = $clog2(RING);
  localparam int ROWW  = HEIGHT_BITS + 1;

  logic [COLW-1:0]  scan_column;
  logic [ROWW-1:0]  scan_row;
  logic [SLOTW-1:0] wr_slot;
  logic [31:0]      span;

  assign span = 2 * 32'(r_eff) + 1;

  always_comb begin
    job_flags.ok        = (op == OP_PIXEL) && sample_valid && (32'(scan_row) < 32'(h_eff));
    job_flags.first_row = (scan_row == '0);
    job_flags.leave_ok  = (32'(scan_row) >= span);
    job_flags.orow_ok   = (32'(scan_row) >= 32'(r_eff));
    job_flags.row_last  = (32'(scan_row) == 32'(h_eff) + 32'(r_eff) - 1);
    job_flags.col_last  = (32'(scan_column) == 32'(w_eff) - 1);
    job_col             = scan_column;
    job_wr_slot         = wr_slot;
    // step back 2r+1 rows around the ring
    job_leave_slot = (32'(wr_slot) >= span) ? SLOTW'(32'(wr_slot) - span)
                                            : SLOTW'(32'(wr_slot) + RING - span);
    job_value = job_flags.ok ? sample : '0;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      scan_column <= '0;
      scan_row    <= '0;
      wr_slot     <= '0;
    end else if (accept) begin
      if (job_flags.col_last) begin
        scan_column <= '0;
        if (job_flags.row_last) begin
          scan_row <= '0;
          wr_slot  <= '0;
        end else begin
          scan_row <= scan_row + 1'b1;
          wr_slot  <= (32'(wr_slot) == RING - 1) ? '0 : wr_slot + 1'b1;
        end
      end else begin
        scan_column <= scan_column + 1'b1;
      end
    end
  end

endmodule

@@ sv/mabm_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mabm_back
// Line store, column sums and sliding row sum; issues window sums in order.
// ----------------------------------------------------------------------------
module mabm_back import mabm_pkg::*; #(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int MAX_RADIUS  = DEF_MAX_RADIUS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                                                   clk,
  input  logic                                                   rst,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]                         w_eff,
  input  logic [$clog2(MAX_RADIUS+1)-1:0]                        r_eff,
  input  logic                                                   q_empty,
  output logic                                                   q_pop,
  input  job_flags_t                                             q_flags,
  input  logic [$clog2(MAX_WIDTH)-1:0]                           q_col,
  input  logic [$clog2(2*MAX_RADIUS+1)-1:0]                      q_wr_slot,
  input  logic [$clog2(2*MAX_RADIUS+1)-1:0]                      q_leave_slot,
  input  logic signed [SAMPLE_BITS-1:0]                          q_value,
  output logic                                                   win_pend,
  input  logic                                                   win_ready,
  output logic signed [SAMPLE_BITS+$clog2((2*MAX_RADIUS+1)**2+1)-1:0] win_sum,
  output logic [$clog2((2*MAX_RADIUS+1)**2+1)-1:0]               win_cnt,
  output res_flags_t                                             win_flags
);

  localparam int COLW  = $clog2(MAX_WIDTH);
  localparam int RING  = 2 * MAX_RADIUS + 1;
  localparam int SLOTW = $clog2(RING);
  localparam int CNTC  = $clog2(RING + 1);
  localparam int CSW   = SAMPLE_BITS + CNTC;
  localparam int WCNT  = $clog2(RING * RING + 1);
  localparam int WSUM  = SAMPLE_BITS + WCNT;
  localparam int VW    = $clog2(MAX_WIDTH + MAX_RADIUS + 1);
  localparam int LSW   = SAMPLE_BITS + 1;
  localparam int CSRW  = CSW + CNTC;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_COL   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0]                state;
  job_flags_t                jflags;
  logic [COLW-1:0]           jcol;
  logic signed [SAMPLE_BITS-1:0] q_value_hold;
  logic [VW-1:0]             vcol;
  logic signed [WSUM-1:0]    hsum;
  logic [WCNT-1:0]           hcnt;
  logic signed [CSW-1:0]     dl_sum [RING];
  logic [CNTC-1:0]           dl_cnt [RING];

  logic [LSW-1:0]            ls_rdata;
  logic [CSRW-1:0]           cs_rdata;
  logic signed [CSW-1:0]     new_sum;
  logic [CNTC-1:0]           new_cnt;
  logic signed [CSW-1:0]     old_sum;
  logic [CNTC-1:0]           old_cnt;
  logic signed [CSW-1:0]     lv_sum;
  logic [CNTC-1:0]           lv_cnt;
  logic signed [CSW-1:0]     ent_sum;
  logic [CNTC-1:0]           ent_cnt;
  logic signed [CSW-1:0]     hl_sum;
  logic [CNTC-1:0]           hl_cnt;
  logic [VW-1:0]             v_cur;
  logic                      step;
  logic                      emit;
  logic                      drain_end;
  logic                      win_take;
  logic signed [WSUM-1:0]    hsum_next;
  logic [WCNT-1:0]           hcnt_next;
  res_flags_t                flags_next;
  logic [SLOTW-1:0]          tap;

  mabm_ram #(.WIDTH(LSW), .DEPTH(RING * (2 ** COLW))) u_line_store (
    .clk   (clk),
    .we    (q_pop),
    .waddr ({q_wr_slot, q_col}),
    .wdata ({q_flags.ok, q_value}),
    .raddr ({q_leave_slot, q_col}),
    .rdata (ls_rdata)
  );

  mabm_ram #(.WIDTH(CSRW), .DEPTH(2 ** COLW)) u_col_sums (
    .clk   (clk),
    .we    (state == S_COL),
    .waddr (jcol),
    .wdata ({new_sum, new_cnt}),
    .raddr (q_col),
    .rdata (cs_rdata)
  );

  assign q_pop    = (state == S_IDLE) && !q_empty && !win_pend;
  assign win_take = win_pend && win_ready;
  assign tap      = SLOTW'(2 * 32'(r_eff));

  always_comb begin
    // a column sum starts afresh on the first row of a frame
    old_sum = jflags.first_row ? '0 : $signed(cs_rdata[CSRW-1:CNTC]);
    old_cnt = jflags.first_row ? '0 : cs_rdata[CNTC-1:0];
    lv_sum  = jflags.leave_ok ? CSW'($signed(ls_rdata[SAMPLE_BITS-1:0])) : '0;
    lv_cnt  = jflags.leave_ok ? CNTC'(ls_rdata[SAMPLE_BITS]) : '0;
    new_sum = old_sum + CSW'(q_value_hold) - lv_sum;
    new_cnt = old_cnt + CNTC'(jflags.ok) - lv_cnt;

    v_cur   = (state == S_COL) ? VW'(jcol) : vcol;
    ent_sum = (state == S_COL) ? new_sum : '0;
    ent_cnt = (state == S_COL) ? new_cnt : '0;
    if (32'(v_cur) >= 2 * 32'(r_eff) + 1) begin
      hl_sum = dl_sum[tap];
      hl_cnt = dl_cnt[tap];
    end else begin
      hl_sum = '0;
      hl_cnt = '0;
    end
    hsum_next = ((v_cur == '0) ? '0 : hsum) + WSUM'(ent_sum) - WSUM'(hl_sum);
    hcnt_next = ((v_cur == '0) ? '0 : hcnt) + WCNT'(ent_cnt) - WCNT'(hl_cnt);

    step      = (state == S_COL) || ((state == S_DRAIN) && !win_pend);
    emit      = step && jflags.orow_ok && (32'(v_cur) >= 32'(r_eff));
    drain_end = (32'(v_cur) == 32'(w_eff) + 32'(r_eff) - 1);
    if (state == S_COL) begin
      flags_next.run_last   = !(jflags.col_last && jflags.orow_ok && (r_eff != '0));
      flags_next.frame_last = jflags.row_last && jflags.col_last && (r_eff == '0);
    end else begin
      flags_next.run_last   = drain_end;
      flags_next.frame_last = jflags.row_last && drain_end;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      jflags       <= q_flags;
      jcol         <= q_col;
      q_value_hold <= q_value;
    end
    if (step) begin
      hsum      <= hsum_next;
      hcnt      <= hcnt_next;
      dl_sum[0] <= ent_sum;
      dl_cnt[0] <= ent_cnt;
      for (int i = 1; i < RING; i++) begin
        dl_sum[i] <= dl_sum[i-1];
        dl_cnt[i] <= dl_cnt[i-1];
      end
    end
    if (emit) begin
      win_sum   <= hsum_next;
      win_cnt   <= hcnt_next;
      win_flags <= flags_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      vcol     <= '0;
      win_pend <= 1'b0;
    end else begin
      if (emit) begin
        win_pend <= 1'b1;
      end else if (win_take) begin
        win_pend <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            state <= S_COL;
          end
        end
        S_COL: begin
          // finish the row with the columns that have no new input
          if (jflags.col_last && jflags.orow_ok && (r_eff != '0)) begin
            state <= S_DRAIN;
            vcol  <= VW'(w_eff);
          end else begin
            state <= S_IDLE;
          end
        end
        S_DRAIN: begin
          if (step) begin
            if (drain_end) begin
              state <= S_IDLE;
            end else begin
              vcol <= vcol + 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "missing_aware_box_mean_macros.svh"

  `MABM_ASSERT_NEXT(a_pend_holds, win_pend && !win_ready, win_pend && $stable(win_sum))
  `MABM_ASSERT_NOW(a_drain_range, state == S_DRAIN,
                   (32'(vcol) >= 32'(w_eff)) && (32'(vcol) < 32'(w_eff) + 32'(r_eff)))
  `MABM_ASSERT_NEXT(a_col_after_pop, q_pop, state == S_COL)
  `MABM_ASSERT_NOW(a_col_no_pend, state == S_COL, !win_pend)

endmodule

@@ sv/mabm_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mabm_div
// Bit-serial rounded division of a window sum by its count, result register.
// ----------------------------------------------------------------------------
module mabm_div import mabm_pkg::*; #(
  parameter int MAX_RADIUS  = DEF_MAX_RADIUS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                                                   clk,
  input  logic                                                   rst,
  input  logic                                                   in_valid,
  output logic                                                   in_ready,
  input  logic signed [SAMPLE_BITS+$clog2((2*MAX_RADIUS+1)**2+1)-1:0] in_sum,
  input  logic [$clog2((2*MAX_RADIUS+1)**2+1)-1:0]               in_cnt,
  input  res_flags_t                                             in_flags,
  output logic                                                   empty,
  input  logic                                                   pop,
  output logic signed [SAMPLE_BITS-1:0]                          mean,
  output logic                                                   mean_valid,
  output logic                                                   run_last,
  output logic                                                   frame_last
);

  localparam int WCNT = $clog2((2 * MAX_RADIUS + 1) ** 2 + 1);
  localparam int WSUM = SAMPLE_BITS + WCNT;
  localparam int NUMW = WSUM + 1;
  localparam int DENW = WCNT + 1;
  localparam int ITW  = $clog2(NUMW + 1);

  logic              busy;
  logic [ITW-1:0]    iter;
  logic [DENW-1:0]   rem;
  logic [NUMW-1:0]   quo;
  logic [DENW-1:0]   den;
  logic              neg;
  logic              nz;
  res_flags_t        flags;
  logic              out_full;
  logic [WSUM-1:0]   mag;
  logic [DENW:0]     trial;
  logic              ge;
  logic              finish;
  logic [SAMPLE_BITS-1:0] qs;

  assign in_ready = !busy;
  assign empty    = !out_full;
  assign mag      = in_sum[WSUM-1] ? WSUM'(-in_sum) : WSUM'(in_sum);
  assign trial    = {rem, quo[NUMW-1]};
  assign ge       = (trial >= {1'b0, den});
  assign finish   = busy && (32'(iter) == NUMW) && (!out_full || pop);
  assign qs       = quo[SAMPLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (in_valid && !busy) begin
      rem   <= '0;
      quo   <= {mag, 1'b0} + NUMW'(in_cnt);
      den   <= {in_cnt, 1'b0};
      neg   <= in_sum[WSUM-1];
      nz    <= (in_cnt != '0);
      flags <= in_flags;
    end else if (busy && (32'(iter) < NUMW)) begin
      rem <= ge ? DENW'(trial - {1'b0, den}) : DENW'(trial);
      quo <= {quo[NUMW-2:0], ge};
    end
    if (finish) begin
      mean       <= nz ? (neg ? -qs : qs) : '0;
      mean_valid <= nz;
      run_last   <= flags.run_last;
      frame_last <= flags.frame_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      iter     <= '0;
      out_full <= 1'b0;
    end else begin
      if (in_valid && !busy) begin
        busy <= 1'b1;
        iter <= '0;
      end else if (busy && (32'(iter) < NUMW)) begin
        iter <= iter + 1'b1;
      end else if (finish) begin
        busy <= 1'b0;
      end
      if (finish) begin
        out_full <= 1'b1;
      end else if (pop) begin
        out_full <= 1'b0;
      end
    end
  end

endmodule

@@ sv/missing_aware_box_mean.sv @@
`timescale 1ns / 1ps
// Path: an item that completes a window passes the input queue, the back end and the
// divider, whose quotient is NUMW = SAMPLE_BITS + clog2((2*MAX_RADIUS+1)^2 + 1) + 1
// bits (27 by default). An item with no result passes S_IDLE and S_COL in the back end;
// the bit-serial divider takes no new window sum while busy and sets the sustained rate.
// Reset (rst, synchronous) and a write to any of the three registers restart the frame;
// the line store is never cleared, as only rows written in the current frame are read.
// ----------------------------------------------------------------------------
// missing_aware_box_mean
// Box mean over a raster with missing samples, clipped at the frame edges.
// ----------------------------------------------------------------------------
module missing_aware_box_mean import mabm_pkg::*; #(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int MAX_RADIUS  = DEF_MAX_RADIUS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data,
  input  logic                          push,
  output logic                          full,
  input  logic                          op,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          sample_valid,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [SAMPLE_BITS-1:0] mean,
  output logic                          mean_valid,
  output logic                          run_last,
  output logic                          frame_last
);

  localparam int COLW  = $clog2(MAX_WIDTH);
  localparam int WEW   = $clog2(MAX_WIDTH + 1);
  localparam int RADW  = $clog2(MAX_RADIUS + 1);
  localparam int RING  = 2 * MAX_RADIUS + 1;
  localparam int SLOTW = $clog2(RING);
  localparam int WCNT  = $clog2(RING * RING + 1);
  localparam int WSUM  = SAMPLE_BITS + WCNT;
  localparam int FW    = $bits(job_flags_t);
  localparam int JW    = FW + COLW + 2 * SLOTW + SAMPLE_BITS;

  logic [WEW-1:0]         w_eff;
  logic [HEIGHT_BITS-1:0] h_eff;
  logic [RADW-1:0]        r_eff;
  logic                   restart;
  logic [WIDTH_BITS-1:0]  wr_width;
  logic [RADIUS_BITS-1:0] wr_radius;

  logic                          q_full;
  logic                          q_empty;
  logic                          q_pop;
  logic                          accept;
  job_flags_t                    f_flags;
  logic [COLW-1:0]               f_col;
  logic [SLOTW-1:0]              f_wr_slot;
  logic [SLOTW-1:0]              f_leave_slot;
  logic signed [SAMPLE_BITS-1:0] f_value;
  logic [JW-1:0]                 q_din;
  logic [JW-1:0]                 q_dout;

  logic                          win_pend;
  logic                          win_ready;
  logic signed [WSUM-1:0]        win_sum;
  logic [WCNT-1:0]               win_cnt;
  res_flags_t                    win_flags;

  assign restart   = cfg_write && ((cfg_index == REG_FRAME_WIDTH) ||
                     (cfg_index == REG_FRAME_HEIGHT) || (cfg_index == REG_WINDOW_RADIUS));
  assign wr_width  = cfg_data[WIDTH_BITS-1:0];
  assign wr_radius = cfg_data[RADIUS_BITS-1:0];

  // hold the clamped register values
  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff <= WEW'(RST_FRAME_WIDTH);
      h_eff <= RST_FRAME_HEIGHT;
      r_eff <= RADW'(RST_WINDOW_RADIUS);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FRAME_WIDTH: begin
          if (wr_width == '0) begin
            w_eff <= WEW'(1);
          end else if (32'(wr_width) > MAX_WIDTH) begin
            w_eff <= WEW'(MAX_WIDTH);
          end else begin
            w_eff <= WEW'(wr_width);
          end
        end
        REG_FRAME_HEIGHT: begin
          h_eff <= (cfg_data == '0) ? HEIGHT_BITS'(1) : cfg_data[HEIGHT_BITS-1:0];
        end
        REG_WINDOW_RADIUS: begin
          r_eff <= (32'(wr_radius) > MAX_RADIUS) ? RADW'(MAX_RADIUS) : RADW'(wr_radius);
        end
        default: begin
          r_eff <= r_eff;
        end
      endcase
    end
  end

  assign full   = q_full;
  assign accept = push && !q_full;
  assign q_din  = {f_flags, f_col, f_wr_slot, f_leave_slot, f_value};

  mabm_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_RADIUS  (MAX_RADIUS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .restart        (restart),
    .w_eff          (w_eff),
    .h_eff          (h_eff),
    .r_eff          (r_eff),
    .accept         (accept),
    .op             (op),
    .sample         (sample),
    .sample_valid   (sample_valid),
    .job_flags      (f_flags),
    .job_col        (f_col),
    .job_wr_slot    (f_wr_slot),
    .job_leave_slot (f_leave_slot),
    .job_value      (f_value)
  );

  mabm_fifo #(.WIDTH(JW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  mabm_back #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_RADIUS  (MAX_RADIUS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .w_eff        (w_eff),
    .r_eff        (r_eff),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .q_flags      (q_dout[JW-1 -: FW]),
    .q_col        (q_dout[JW-FW-1 -: COLW]),
    .q_wr_slot    (q_dout[SAMPLE_BITS+2*SLOTW-1 -: SLOTW]),
    .q_leave_slot (q_dout[SAMPLE_BITS+SLOTW-1 -: SLOTW]),
    .q_value      ($signed(q_dout[SAMPLE_BITS-1:0])),
    .win_pend     (win_pend),
    .win_ready    (win_ready),
    .win_sum      (win_sum),
    .win_cnt      (win_cnt),
    .win_flags    (win_flags)
  );

  mabm_div #(
    .MAX_RADIUS  (MAX_RADIUS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (win_pend),
    .in_ready   (win_ready),
    .in_sum     (win_sum),
    .in_cnt     (win_cnt),
    .in_flags   (win_flags),
    .empty      (empty),
    .pop        (pop),
    .mean       (mean),
    .mean_valid (mean_valid),
    .run_last   (run_last),
    .frame_last (frame_last)
  );

endmodule
